>>> design/i2cm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package i2cm_pkg;

    // Field and register widths fixed by the bus format.
    localparam int HP_W = 16;
    localparam int BYTE_W = 8;

    localparam int DELAY_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [HP_W-1:0] HALF_PERIOD_RESET = 16'd8;

    // Command codes on the input item.
    localparam logic [1:0] CMD_TX = 2'd1;
    localparam logic [1:0] CMD_RX = 2'd2;

    // Bit counter marks: eight data bits, then the acknowledge bit.
    localparam logic [3:0] BIT_ACK = 4'd8;
    localparam logic [3:0] BIT_END = 4'd9;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_TX,
        OP_RX
    } t_op;

    typedef struct packed {
        logic [1:0]        command;
        logic              start_req;
        logic              stop_req;
        logic [BYTE_W-1:0] tx_byte;
        logic              nak_to_send;
        logic              scl_line;
        logic              sda_line;
    } t_in_item;

    typedef struct packed {
        logic              scl_drive_low;
        logic              sda_drive_low;
        logic              busy_res;
        logic              byte_done;
        logic [BYTE_W-1:0] rx_data;
        logic              nack_received;
        logic              arb_lost;
    } t_out_item;

    // Classified tick as it sits in the queue.
    typedef struct packed {
        t_op               op;
        logic              start_req;
        logic              stop_req;
        logic [BYTE_W-1:0] tx_byte;
        logic              nak_to_send;
        logic              scl_line;
        logic              sda_line;
    } t_tick;

endpackage
`default_nettype wire

>>> design/i2c_master_byte_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// I2C master byte engine: one transfer in per bus clock tick, one result out per tick.
// Each input transfer is written into the queue, then the engine step registers its result.
// The engine takes one transfer per cycle while the result channel does not stall.
// Reset (synchronous, active low): engine idle, lines released, flags cleared,
// queue empty, half period back to 8 ticks.
module i2c_master_byte_engine #(
    parameter int DELAY_BITS  = i2cm_pkg::DELAY_BITS_DEF,
    parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    // half-period register write
    input  wire                         i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire [i2cm_pkg::HP_W-1:0]    i_cfg_data,
    // tick input channel
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire i2cm_pkg::t_in_item     i_in_item,
    // result channel
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output i2cm_pkg::t_out_item         o_out_item
);

    i2cm_pkg::t_tick front_tick;
    i2cm_pkg::t_tick q_tick;
    logic            q_full;
    logic            q_valid;
    logic            pop;

    // The user must write only while idle (not enforced); the port is always open.
    assign o_cfg_ready = 1'b1;
    // Hold off the sender only when the queue has no room.
    assign o_in_stall  = q_full;

    // Front: classify the tick's command.
    i2cm_front u_front (
        .i_item (i_in_item),
        .o_tick (front_tick)
    );

    // Short queue decouples intake from the engine and its result register.
    i2cm_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_tick  (front_tick),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_tick  (q_tick)
    );

    // Back: advance the bus sequencer one tick per popped entry.
    i2cm_back #(
        .DELAY_BITS (DELAY_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_write (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_tick      (q_tick),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

>>> design/i2cm_front.sv
`timescale 1ns / 1ps
`default_nettype none
module i2cm_front (
    input  wire i2cm_pkg::t_in_item i_item,
    output i2cm_pkg::t_tick         o_tick
);

    // Decode the command; unused code 3 behaves like no command.
    always_comb begin
        case (i_item.command)
            i2cm_pkg::CMD_TX: o_tick.op = i2cm_pkg::OP_TX;
            i2cm_pkg::CMD_RX: o_tick.op = i2cm_pkg::OP_RX;
            default:          o_tick.op = i2cm_pkg::OP_NONE;
        endcase
        // Start applies to transmit only.
        o_tick.start_req   = i_item.start_req && (i_item.command == i2cm_pkg::CMD_TX);
        o_tick.stop_req    = i_item.stop_req;
        o_tick.tx_byte     = i_item.tx_byte;
        o_tick.nak_to_send = i_item.nak_to_send;
        o_tick.scl_line    = i_item.scl_line;
        o_tick.sda_line    = i_item.sda_line;
    end

endmodule
`default_nettype wire

>>> design/i2cm_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module i2cm_queue #(
    parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_push,
    input  wire i2cm_pkg::t_tick   i_tick,
    output logic                   o_full,
    output logic                   o_valid,
    input  wire                    i_pop,
    output i2cm_pkg::t_tick        o_tick
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    i2cm_pkg::t_tick r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_tick  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> design/i2cm_back.sv
`timescale 1ns / 1ps
`default_nettype none
module i2cm_back #(
    parameter int DELAY_BITS = i2cm_pkg::DELAY_BITS_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_write,
    input  wire [i2cm_pkg::HP_W-1:0]    i_cfg_data,
    input  wire                         i_q_valid,
    input  wire i2cm_pkg::t_tick        i_tick,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output i2cm_pkg::t_out_item         o_out_item
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ST_CHECK,
        PH_ST_HOLD,
        PH_RS_SETUP,
        PH_RS_SCL,
        PH_BIT_SETUP,
        PH_BIT_HIGH,
        PH_BIT_HOLD,
        PH_STOP_SETUP,
        PH_STOP_HIGH,
        PH_STOP_CHECK,
        PH_STOP_HOLD
    } t_phase;

    localparam logic [32:0] DELAY_MAX = (33'd1 << DELAY_BITS) - 33'd1;

    logic [i2cm_pkg::HP_W-1:0] r_half_period;

    t_phase                      r_phase, n_phase;
    logic [3:0]                  r_bit, n_bit;
    logic [i2cm_pkg::BYTE_W-1:0] r_shift, n_shift;
    logic [DELAY_BITS-1:0]       r_delay, n_delay;
    logic                        r_start_sent, n_start_sent;
    logic                        r_fl_tx, n_fl_tx;
    logic                        r_fl_stop, n_fl_stop;
    logic                        r_fl_nak, n_fl_nak;
    logic                        r_ack, n_ack;
    logic                        r_arb, n_arb;
    logic                        r_drv_scl, n_drv_scl;
    logic                        r_drv_sda, n_drv_sda;
    logic [i2cm_pkg::BYTE_W-1:0] r_rx, n_rx;
    logic                        n_done;

    logic                  r_out_valid;
    i2cm_pkg::t_out_item   r_out;

    logic [DELAY_BITS-1:0] load_val;
    logic                  delay_fin;
    logic [DELAY_BITS-1:0] delay_dec;
    logic                  cur_read;
    logic                  cur_write;
    logic [3:0]            bit_inc;
    logic [i2cm_pkg::BYTE_W-1:0] shift_end;

    // SDA level for a bit slot: release on read slots and on one bits.
    function automatic logic sda_for_bit(input logic tx, input logic nak,
                                         input logic [3:0] idx,
                                         input logic [i2cm_pkg::BYTE_W-1:0] sh);
        logic rd;
        logic wr;
        rd = tx ? (idx >= i2cm_pkg::BIT_ACK) : (idx < i2cm_pkg::BIT_ACK);
        wr = tx ? sh[i2cm_pkg::BYTE_W-1] : nak;
        return !(rd || wr);
    endfunction

    assign o_pop       = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        load_val  = (33'(r_half_period) > DELAY_MAX) ? '1 : DELAY_BITS'(r_half_period);
        delay_fin = (r_delay <= DELAY_BITS'(1));
        delay_dec = r_delay - 1'b1;
        cur_read  = r_fl_tx ? (r_bit >= i2cm_pkg::BIT_ACK) : (r_bit < i2cm_pkg::BIT_ACK);
        cur_write = r_fl_tx ? r_shift[i2cm_pkg::BYTE_W-1] : r_fl_nak;
        bit_inc   = r_bit + 1'b1;
        shift_end = (r_fl_tx && (r_bit < i2cm_pkg::BIT_ACK))
                  ? {r_shift[i2cm_pkg::BYTE_W-2:0], 1'b0} : r_shift;
    end

    always_comb begin
        n_phase      = r_phase;
        n_bit        = r_bit;
        n_shift      = r_shift;
        n_delay      = r_delay;
        n_start_sent = r_start_sent;
        n_fl_tx      = r_fl_tx;
        n_fl_stop    = r_fl_stop;
        n_fl_nak     = r_fl_nak;
        n_ack        = r_ack;
        n_arb        = r_arb;
        n_drv_scl    = r_drv_scl;
        n_drv_sda    = r_drv_sda;
        n_rx         = r_rx;
        n_done       = 1'b0;

        case (r_phase)
            PH_IDLE: begin
                if (i_tick.op != i2cm_pkg::OP_NONE) begin
                    n_fl_tx   = (i_tick.op == i2cm_pkg::OP_TX);
                    n_fl_stop = i_tick.stop_req;
                    n_fl_nak  = i_tick.nak_to_send;
                    n_bit     = '0;
                    n_shift   = n_fl_tx ? i_tick.tx_byte : '0;
                    if (i_tick.start_req) begin
                        n_drv_sda = 1'b0;
                        if (r_start_sent) begin
                            n_delay = load_val;
                            n_phase = PH_RS_SETUP;
                        end else begin
                            n_phase = PH_ST_CHECK;
                        end
                    end else begin
                        n_phase   = PH_BIT_SETUP;
                        n_drv_sda = sda_for_bit(n_fl_tx, n_fl_nak, '0, n_shift);
                        n_delay   = load_val;
                    end
                end
            end
            PH_ST_CHECK: begin
                if (!i_tick.sda_line) begin
                    n_arb = 1'b1;
                end
                n_drv_sda = 1'b1;
                n_delay   = load_val;
                n_phase   = PH_ST_HOLD;
            end
            PH_ST_HOLD: begin
                n_delay = delay_fin ? '0 : delay_dec;
                if (delay_fin) begin
                    n_drv_scl    = 1'b1;
                    n_start_sent = 1'b1;
                    n_bit        = '0;
                    n_phase      = PH_BIT_SETUP;
                    n_drv_sda    = sda_for_bit(r_fl_tx, r_fl_nak, '0, r_shift);
                    n_delay      = load_val;
                end
            end
            PH_RS_SETUP, PH_BIT_SETUP, PH_STOP_SETUP: begin
                n_delay = delay_fin ? '0 : delay_dec;
                if (delay_fin) begin
                    n_drv_scl = 1'b0;
                    case (r_phase)
                        PH_RS_SETUP:  n_phase = PH_RS_SCL;
                        PH_BIT_SETUP: n_phase = PH_BIT_HIGH;
                        default:      n_phase = PH_STOP_HIGH;
                    endcase
                end
            end
            PH_RS_SCL: begin
                // Wait out clock stretching before checking the start.
                if (i_tick.scl_line) begin
                    if (!i_tick.sda_line) begin
                        n_arb = 1'b1;
                    end
                    n_drv_sda = 1'b1;
                    n_delay   = load_val;
                    n_phase   = PH_ST_HOLD;
                end
            end
            PH_BIT_HIGH: begin
                if (i_tick.scl_line) begin
                    if (cur_read) begin
                        if (r_fl_tx) begin
                            n_ack = i_tick.sda_line;
                        end else begin
                            n_shift = {r_shift[i2cm_pkg::BYTE_W-2:0], i_tick.sda_line};
                        end
                    end else if (cur_write && !i_tick.sda_line) begin
                        n_arb = 1'b1;
                    end
                    n_delay = load_val;
                    n_phase = PH_BIT_HOLD;
                end
            end
            PH_BIT_HOLD: begin
                n_delay = delay_fin ? '0 : delay_dec;
                if (delay_fin) begin
                    n_drv_scl = 1'b1;
                    n_shift   = shift_end;
                    n_bit     = bit_inc;
                    if (bit_inc < i2cm_pkg::BIT_END) begin
                        n_phase   = PH_BIT_SETUP;
                        n_drv_sda = sda_for_bit(r_fl_tx, r_fl_nak, bit_inc, shift_end);
                        n_delay   = load_val;
                    end else begin
                        if (!r_fl_tx) begin
                            n_rx = r_shift;
                        end
                        if (r_fl_stop) begin
                            n_drv_sda = 1'b1;
                            n_delay   = load_val;
                            n_phase   = PH_STOP_SETUP;
                        end else begin
                            n_phase = PH_IDLE;
                            n_done  = 1'b1;
                        end
                    end
                end
            end
            PH_STOP_HIGH: begin
                if (i_tick.scl_line) begin
                    n_drv_sda = 1'b0;
                    n_phase   = PH_STOP_CHECK;
                end
            end
            PH_STOP_CHECK: begin
                if (!i_tick.sda_line) begin
                    n_arb = 1'b1;
                end
                n_delay = load_val;
                n_phase = PH_STOP_HOLD;
            end
            PH_STOP_HOLD: begin
                n_delay = delay_fin ? '0 : delay_dec;
                if (delay_fin) begin
                    n_start_sent = 1'b0;
                    n_phase      = PH_IDLE;
                    n_done       = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= i2cm_pkg::HALF_PERIOD_RESET;
        end else if (i_cfg_write) begin
            r_half_period <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit        <= '0;
            r_shift      <= '0;
            r_delay      <= '0;
            r_start_sent <= 1'b0;
            r_fl_tx      <= 1'b0;
            r_fl_stop    <= 1'b0;
            r_fl_nak     <= 1'b0;
            r_ack        <= 1'b0;
            r_arb        <= 1'b0;
            r_drv_scl    <= 1'b0;
            r_drv_sda    <= 1'b0;
            r_rx         <= '0;
            r_out_valid  <= 1'b0;
            r_out        <= '0;
        end else if (o_pop) begin
            r_phase      <= n_phase;
            r_bit        <= n_bit;
            r_shift      <= n_shift;
            r_delay      <= n_delay;
            r_start_sent <= n_start_sent;
            r_fl_tx      <= n_fl_tx;
            r_fl_stop    <= n_fl_stop;
            r_fl_nak     <= n_fl_nak;
            r_ack        <= n_ack;
            r_arb        <= n_arb;
            r_drv_scl    <= n_drv_scl;
            r_drv_sda    <= n_drv_sda;
            r_rx         <= n_rx;
            r_out_valid  <= 1'b1;
            r_out.scl_drive_low <= n_drv_scl;
            r_out.sda_drive_low <= n_drv_sda;
            r_out.busy_res      <= (n_phase != PH_IDLE);
            r_out.byte_done     <= n_done;
            r_out.rx_data       <= n_rx;
            r_out.nack_received <= n_ack;
            r_out.arb_lost      <= n_arb;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule
`default_nettype wire

>>> test/i2c_master_byte_engine_test.sv
`timescale 1ns / 1ps
module i2c_master_byte_engine_test;

    localparam logic [1:0] CMD_IDLE     = 2'd0;
    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam int         WATCHDOG_LIMIT = 1000;
    localparam int         MAX_REPORTS    = 40;
    localparam int         IN_W = $bits(i2cm_pkg::t_in_item);

    // Engine phases, kept in step with the block one tick at a time.
    typedef enum logic [3:0] {
        S_IDLE,
        S_START_CHECK,
        S_START_HOLD,
        S_RESTART_SETUP,
        S_RESTART_HIGH,
        S_BIT_SETUP,
        S_BIT_HIGH,
        S_BIT_HOLD,
        S_STOP_SETUP,
        S_STOP_HIGH,
        S_STOP_CHECK,
        S_STOP_HOLD
    } t_eng_phase;

    // What goes in the command field of ticks that should not start anything new.
    typedef enum logic [1:0] {
        FILL_QUIET,
        FILL_IDLE,
        FILL_COMMANDS,
        FILL_ANY
    } t_fill;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [i2cm_pkg::HP_W-1:0]     cfg_data;
    logic                          in_valid;
    logic                          in_stall;
    i2cm_pkg::t_in_item            in_item;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    i2cm_pkg::t_out_item           out_item;

    i2c_master_byte_engine i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    // ------------------------------------------------------------------
    // Engine state as predicted from the accepted ticks
    // ------------------------------------------------------------------
    logic [i2cm_pkg::HP_W-1:0]   hp_cfg     = i2cm_pkg::HALF_PERIOD_RESET;
    t_eng_phase                  eng_phase  = S_IDLE;
    logic [3:0]                  bit_cnt    = '0;
    logic [i2cm_pkg::BYTE_W-1:0] shifter    = '0;
    logic [15:0]                 delay_left = '0;
    logic                        start_sent = 1'b0;
    logic                        tx_mode    = 1'b0;
    logic                        stop_pend  = 1'b0;
    logic                        nak_pend   = 1'b0;
    logic                        ack_seen   = 1'b0;
    logic                        arb_lost   = 1'b0;
    logic                        drv_scl    = 1'b0;
    logic                        drv_sda    = 1'b0;
    logic [i2cm_pkg::BYTE_W-1:0] rx_last    = '0;
    logic                        done_now   = 1'b0;

    // Status words still owed by the block, oldest first.
    i2cm_pkg::t_out_item status_due_q[$];

    // Stimulus knobs, in percent.
    int gap_pct     = 0;
    int stall_pct   = 0;
    int stretch_pct = 0;
    int arb_pct     = 0;
    int noise_pct   = 0;
    int stretch_left = 0;

    int errors      = 0;
    int tick_count  = 0;
    int tx_count    = 0;
    int rx_count    = 0;
    int done_count  = 0;
    int idle_cycles = 0;

    function automatic void load_half_delay();
        delay_left = hp_cfg;
    endfunction

    // Count down one tick; a loaded zero behaves like one.
    function automatic bit half_delay_elapsed();
        if (delay_left > 16'd1) begin
            delay_left = delay_left - 16'd1;
            return 1'b0;
        end
        delay_left = '0;
        return 1'b1;
    endfunction

    // Transmit reads only the acknowledge slot; receive reads the eight data bits.
    function automatic bit reading_bit();
        return tx_mode ? (bit_cnt >= i2cm_pkg::BIT_ACK) : (bit_cnt < i2cm_pkg::BIT_ACK);
    endfunction

    function automatic bit bit_level();
        return tx_mode ? shifter[i2cm_pkg::BYTE_W-1] : nak_pend;
    endfunction

    function automatic void setup_bit();
        eng_phase = S_BIT_SETUP;
        drv_sda   = !(reading_bit() || bit_level());
        load_half_delay();
    endfunction

    function automatic void check_start_sda(logic sda);
        if (!sda) begin
            arb_lost = 1'b1;
        end
        drv_sda = 1'b1;
        load_half_delay();
        eng_phase = S_START_HOLD;
    endfunction

    function automatic void close_bit();
        drv_scl = 1'b1;
        if (tx_mode && bit_cnt < i2cm_pkg::BIT_ACK) begin
            shifter = shifter << 1;
        end
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt < i2cm_pkg::BIT_END) begin
            setup_bit();
        end else begin
            if (!tx_mode) begin
                rx_last = shifter;
            end
            if (stop_pend) begin
                drv_sda = 1'b1;
                load_half_delay();
                eng_phase = S_STOP_SETUP;
            end else begin
                eng_phase = S_IDLE;
                done_now  = 1'b1;
            end
        end
    endfunction

    // Advance the engine by one tick and return the status it shows afterwards.
    function automatic i2cm_pkg::t_out_item engine_step(i2cm_pkg::t_in_item it);
        i2cm_pkg::t_out_item r;
        done_now = 1'b0;
        case (eng_phase)
            S_IDLE: begin
                if (it.command == i2cm_pkg::CMD_TX || it.command == i2cm_pkg::CMD_RX) begin
                    tx_mode   = (it.command == i2cm_pkg::CMD_TX);
                    stop_pend = it.stop_req;
                    nak_pend  = it.nak_to_send;
                    bit_cnt   = '0;
                    shifter   = tx_mode ? it.tx_byte : '0;
                    if (tx_mode && it.start_req) begin
                        drv_sda = 1'b0;
                        if (start_sent) begin
                            load_half_delay();
                            eng_phase = S_RESTART_SETUP;
                        end else begin
                            eng_phase = S_START_CHECK;
                        end
                    end else begin
                        setup_bit();
                    end
                end
            end
            S_START_CHECK: begin
                check_start_sda(it.sda_line);
            end
            S_START_HOLD: begin
                if (half_delay_elapsed()) begin
                    drv_scl    = 1'b1;
                    start_sent = 1'b1;
                    bit_cnt    = '0;
                    setup_bit();
                end
            end
            S_RESTART_SETUP: begin
                if (half_delay_elapsed()) begin
                    drv_scl   = 1'b0;
                    eng_phase = S_RESTART_HIGH;
                end
            end
            S_RESTART_HIGH: begin
                if (it.scl_line) begin
                    check_start_sda(it.sda_line);
                end
            end
            S_BIT_SETUP: begin
                if (half_delay_elapsed()) begin
                    drv_scl   = 1'b0;
                    eng_phase = S_BIT_HIGH;
                end
            end
            S_BIT_HIGH: begin
                // hold here while the slave stretches the clock
                if (it.scl_line) begin
                    if (reading_bit()) begin
                        if (tx_mode) begin
                            ack_seen = it.sda_line;
                        end else begin
                            shifter = {shifter[i2cm_pkg::BYTE_W-2:0], it.sda_line};
                        end
                    end else if (bit_level() && !it.sda_line) begin
                        arb_lost = 1'b1;
                    end
                    load_half_delay();
                    eng_phase = S_BIT_HOLD;
                end
            end
            S_BIT_HOLD: begin
                if (half_delay_elapsed()) begin
                    close_bit();
                end
            end
            S_STOP_SETUP: begin
                if (half_delay_elapsed()) begin
                    drv_scl   = 1'b0;
                    eng_phase = S_STOP_HIGH;
                end
            end
            S_STOP_HIGH: begin
                if (it.scl_line) begin
                    drv_sda   = 1'b0;
                    eng_phase = S_STOP_CHECK;
                end
            end
            S_STOP_CHECK: begin
                if (!it.sda_line) begin
                    arb_lost = 1'b1;
                end
                load_half_delay();
                eng_phase = S_STOP_HOLD;
            end
            S_STOP_HOLD: begin
                if (half_delay_elapsed()) begin
                    start_sent = 1'b0;
                    eng_phase  = S_IDLE;
                    done_now   = 1'b1;
                end
            end
            default: begin
                eng_phase = S_IDLE;
            end
        endcase
        r.scl_drive_low = drv_scl;
        r.sda_drive_low = drv_sda;
        r.busy_res      = (eng_phase != S_IDLE);
        r.byte_done     = done_now;
        r.rx_data       = rx_last;
        r.nack_received = ack_seen;
        r.arb_lost      = arb_lost;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset, stall and watchdog
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Stall the result channel at random; drop to zero stall when the knob is zero.
    always @(negedge clk) begin
        out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    // Count cycles without any transfer on any channel; give up at the limit.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t ns: watchdog, no transfer for %0d cycles, %0d results owed",
                     $time, WATCHDOG_LIMIT, status_due_q.size());
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [i2cm_pkg::BYTE_W-1:0] exp_val,
                               logic [i2cm_pkg::BYTE_W-1:0] got_val);
        if (exp_val !== got_val) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                         $time, name, exp_val, got_val);
            end
        end
    endtask

    always @(posedge clk) begin : result_check
        i2cm_pkg::t_out_item due;
        if (rst_n && out_valid && !out_stall) begin
            if (out_item.byte_done === 1'b1) begin
                done_count++;
            end
            if (status_due_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("%0t ns: unexpected result, expected none, actual %0h",
                             $time, out_item);
                end
            end else begin
                due = status_due_q.pop_front();
                check_field("scl_drive_low", due.scl_drive_low, out_item.scl_drive_low);
                check_field("sda_drive_low", due.sda_drive_low, out_item.sda_drive_low);
                check_field("busy_res", due.busy_res, out_item.busy_res);
                check_field("byte_done", due.byte_done, out_item.byte_done);
                check_field("rx_data", due.rx_data, out_item.rx_data);
                check_field("nack_received", due.nack_received, out_item.nack_received);
                check_field("arb_lost", due.arb_lost, out_item.arb_lost);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Fill in the bus levels a tick samples, then transfer it. The lines follow what
    // the engine drives; a released SCL may be stretched by the slave, a released
    // SDA carries slave data on read bits and may be pulled low by a rival master.
    task automatic bus_tick(i2cm_pkg::t_in_item it);
        if (noise_pct > 0 && $urandom_range(99) < noise_pct) begin
            it.scl_line = 1'($urandom);
            it.sda_line = 1'($urandom);
        end else begin
            if (drv_scl) begin
                it.scl_line = 1'b0;
            end else if (stretch_left > 0) begin
                it.scl_line = 1'b0;
                stretch_left--;
            end else if ($urandom_range(99) < stretch_pct) begin
                it.scl_line  = 1'b0;
                stretch_left = $urandom_range(0, 5);
            end else begin
                it.scl_line = 1'b1;
            end
            if (drv_sda) begin
                it.sda_line = 1'b0;
            end else if (eng_phase == S_BIT_HIGH && reading_bit()) begin
                it.sda_line = 1'($urandom);
            end else begin
                it.sda_line = !($urandom_range(99) < arb_pct);
            end
        end

        @(negedge clk);
        // sender gaps: drop valid for a random run of cycles
        while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_item  = it;
        do begin
            @(posedge clk);
        end while (in_stall);
        status_due_q.push_back(engine_step(it));
        tick_count++;
    endtask

    // One tick that starts nothing new while busy; idle fill uses no-op codes only.
    task automatic filler_tick(t_fill fill);
        i2cm_pkg::t_in_item it;
        it = IN_W'($urandom);
        case (fill)
            FILL_QUIET: begin
                it.command = CMD_IDLE;
            end
            FILL_IDLE: begin
                it.command = $urandom_range(1) ? CMD_IDLE : CMD_RESERVED;
            end
            FILL_COMMANDS: begin
                it.command = $urandom_range(1) ? i2cm_pkg::CMD_TX : i2cm_pkg::CMD_RX;
            end
            default: begin
            end
        endcase
        bus_tick(it);
    endtask

    task automatic begin_transfer(logic [1:0] cmd, logic st, logic sp,
                                  logic [i2cm_pkg::BYTE_W-1:0] data, logic nak);
        i2cm_pkg::t_in_item it;
        it             = '0;
        it.command     = cmd;
        it.start_req   = st;
        it.stop_req    = sp;
        it.tx_byte     = data;
        it.nak_to_send = nak;
        if (cmd == i2cm_pkg::CMD_TX) begin
            tx_count++;
        end else if (cmd == i2cm_pkg::CMD_RX) begin
            rx_count++;
        end
        bus_tick(it);
    endtask

    // Issue one command from idle and tick until the engine is idle again.
    task automatic transfer_byte(logic [1:0] cmd, logic st, logic sp,
                                 logic [i2cm_pkg::BYTE_W-1:0] data, logic nak, t_fill fill);
        begin_transfer(cmd, st, sp, data, nak);
        while (eng_phase != S_IDLE) begin
            filler_tick(fill);
        end
    endtask

    // Write the half period once every owed result is back.
    task automatic set_half_period(logic [i2cm_pkg::HP_W-1:0] value);
        @(negedge clk);
        in_valid = 1'b0;
        while (status_due_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do begin
            @(posedge clk);
        end while (!cfg_ready);
        hp_cfg = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Idle ticks with the no-op and the unused command code.
    task automatic test_idle_ticks();
        repeat (6) filler_tick(FILL_IDLE);
    endtask

    // First start at the reset half period, repeated start, no start, start after stop.
    task automatic test_transmit();
        transfer_byte(i2cm_pkg::CMD_TX, 1'b1, 1'b0, 8'hA5, 1'b0, FILL_QUIET);
        set_half_period(16'd1);
        transfer_byte(i2cm_pkg::CMD_TX, 1'b1, 1'b0, 8'h00, 1'b1, FILL_QUIET);
        transfer_byte(i2cm_pkg::CMD_TX, 1'b0, 1'b1, 8'hFF, 1'b0, FILL_QUIET);
        transfer_byte(i2cm_pkg::CMD_TX, 1'b1, 1'b1, 8'h5A, 1'b1, FILL_QUIET);
    endtask

    // Receive with ack and with nak; a start request on a receive must be ignored.
    task automatic test_receive();
        transfer_byte(i2cm_pkg::CMD_RX, 1'b1, 1'b0, 8'hFF, 1'b0, FILL_QUIET);
        transfer_byte(i2cm_pkg::CMD_RX, 1'b0, 1'b1, 8'h00, 1'b1, FILL_QUIET);
    endtask

    // Keep offering commands while busy, the finishing tick included.
    task automatic test_busy_commands();
        transfer_byte(i2cm_pkg::CMD_TX, 1'b1, 1'b1, 8'($urandom), 1'b0, FILL_COMMANDS);
        transfer_byte(i2cm_pkg::CMD_RX, 1'b0, 1'b0, 8'($urandom), 1'b0, FILL_COMMANDS);
    endtask

    // Stretch SCL at every high phase: start, repeated start, bits and stop.
    task automatic test_clock_stretching();
        stretch_pct = 60;
        transfer_byte(i2cm_pkg::CMD_TX, 1'b1, 1'b0, 8'h3C, 1'b0, FILL_QUIET);
        transfer_byte(i2cm_pkg::CMD_TX, 1'b1, 1'b1, 8'hC3, 1'b0, FILL_QUIET);
        stretch_pct = 0;
    endtask

    // Pull released SDA low often so the sticky flag gets set.
    task automatic test_arbitration();
        arb_pct = 50;
        transfer_byte(i2cm_pkg::CMD_TX, 1'b1, 1'b1, 8'hFF, 1'b0, FILL_QUIET);
        arb_pct = 0;
    endtask

    // Zero half period, then a long one for a single delay only.
    task automatic test_half_period_extremes();
        set_half_period(16'd0);
        transfer_byte(i2cm_pkg::CMD_TX, 1'b1, 1'b0, 8'h81, 1'b0, FILL_QUIET);
        transfer_byte(i2cm_pkg::CMD_RX, 1'b0, 1'b1, 8'h00, 1'b1, FILL_QUIET);
        set_half_period(16'd150);
        begin_transfer(i2cm_pkg::CMD_RX, 1'b0, 1'b1, 8'h00, 1'b0);
        repeat (100) filler_tick(FILL_QUIET);
        // shorten what follows while the long delay still runs
        set_half_period(16'd1);
        while (eng_phase != S_IDLE) begin
            filler_tick(FILL_QUIET);
        end
    endtask

    // Mostly well-formed commands with random content, some idle and broken ticks.
    task automatic test_random_traffic(int gap, int stall, logic [i2cm_pkg::HP_W-1:0] hp,
                                       int n_ticks);
        int         target;
        int         pick;
        logic [1:0] cmd;
        gap_pct   = gap;
        stall_pct = stall;
        set_half_period(hp);
        stretch_pct = 10;
        arb_pct     = 3;
        noise_pct   = 4;
        target      = tick_count + n_ticks;
        while (tick_count < target) begin
            if ($urandom_range(99) < 25) begin
                repeat ($urandom_range(1, 4)) filler_tick(FILL_IDLE);
            end
            pick = $urandom_range(9);
            cmd  = (pick < 5) ? i2cm_pkg::CMD_TX : (pick < 9) ? i2cm_pkg::CMD_RX : CMD_RESERVED;
            transfer_byte(cmd, 1'($urandom), 1'($urandom), 8'($urandom), 1'($urandom),
                          FILL_ANY);
        end
        stretch_pct = 0;
        arb_pct     = 0;
        noise_pct   = 0;
    endtask

    initial begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_item   = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_idle_ticks();
        test_transmit();
        test_receive();
        test_busy_commands();
        test_clock_stretching();
        test_arbitration();
        test_half_period_extremes();
        test_random_traffic(0, 0, 16'd0, 170);
        test_random_traffic(66, 0, 16'd3, 170);
        test_random_traffic(0, 66, 16'd1, 170);
        test_random_traffic(18, 18, 16'd2, 170);

        // drain the owed results, then allow the pipeline latency for strays
        @(negedge clk);
        in_valid = 1'b0;
        while (status_due_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);

        $display("Ran %0d bus ticks: %0d transmit and %0d receive commands, %0d completions.",
                 tick_count, tx_count, rx_count, done_count);
        $display("Covered half periods 0 to 150, stretching, arbitration and stall mixes.");
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
